@@ rtl/sbus_frame_encoder_scaled_core_assert.svh @@
// Assertion macros for the SBUS frame encoder core.
`ifndef SBUS_FRAME_ENCODER_SCALED_CORE_ASSERT_SVH
`define SBUS_FRAME_ENCODER_SCALED_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SBUSFE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SBUSFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sbusfe_pkg.sv @@
`default_nettype none

package sbusfe_pkg;

  localparam int NUM_W     = 26;
  localparam int NUM_MAG_W = 25;
  localparam int DIV_W     = 12;
  localparam int QUOT_W    = 12;
  localparam int CODE_W    = 11;
  localparam int BYTE_W    = 8;
  localparam int STORE_W   = 18;
  localparam int HELD_W    = 5;
  localparam int IDX_W     = 5;

  localparam logic [CODE_W-1:0] CODE_MAX = 11'h7FF;

  localparam logic [BYTE_W-1:0] FRAME_HEADER = 8'h0F;
  localparam logic [BYTE_W-1:0] FRAME_FOOTER = 8'h00;
  localparam logic [IDX_W-1:0]  FOOTER_INDEX = 5'd24;

  localparam logic [1:0] REG_IN_LOW   = 2'd0;
  localparam logic [1:0] REG_IN_HIGH  = 2'd1;
  localparam logic [1:0] REG_OUT_LOW  = 2'd2;
  localparam logic [1:0] REG_OUT_HIGH = 2'd3;

  localparam logic [11:0] IN_LOW_RESET   = 12'd1000;
  localparam logic [11:0] IN_HIGH_RESET  = 12'd2000;
  localparam logic [10:0] OUT_LOW_RESET  = 11'd173;
  localparam logic [10:0] OUT_HIGH_RESET = 11'd1811;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_MUL_A = 10'b00_0000_0010,
    S_MUL_B = 10'b00_0000_0100,
    S_ADD   = 10'b00_0000_1000,
    S_SIGN  = 10'b00_0001_0000,
    S_DIV   = 10'b00_0010_0000,
    S_PACK  = 10'b00_0100_0000,
    S_EMIT  = 10'b00_1000_0000,
    S_FLAG  = 10'b01_0000_0000,
    S_FOOT  = 10'b10_0000_0000
  } state_t;

endpackage

`default_nettype wire

@@ rtl/sbusfe_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
// Quotient MSB set means the true quotient is 2^(QUOT_W-1) or more.
module sbusfe_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [sbusfe_pkg::NUM_MAG_W-1:0] dividend,
  input  logic [sbusfe_pkg::DIV_W-1:0]     divisor,
  output logic                             done,
  output logic [sbusfe_pkg::QUOT_W-1:0]    quotient
);

  localparam int STEP_W = $clog2(sbusfe_pkg::QUOT_W);

  logic                             busy;
  logic [STEP_W-1:0]                step;
  logic [sbusfe_pkg::NUM_MAG_W-1:0] rem;
  logic [sbusfe_pkg::NUM_MAG_W-1:0] dvs;
  logic                             ge;

  assign ge = (rem >= dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(sbusfe_pkg::QUOT_W - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dvs <= sbusfe_pkg::NUM_MAG_W'(divisor) << (sbusfe_pkg::QUOT_W - 1);
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dvs;
      end
      dvs      <= dvs >> 1;
      quotient <= {quotient[sbusfe_pkg::QUOT_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ rtl/sbus_frame_encoder_scaled_core.sv @@
// SBUS frame encoder with linear scaling. Feed channel values 0..15 in order, one
// transaction each; the core maps each from [in_low, in_high] onto [out_low, out_high]
// (truncated toward zero, clamped to 0..2047), packs the 11-bit codes LSB first and
// emits the 25-byte frame (header 0x0F, 22 data bytes, flags, footer 0x00) one byte per
// output transaction, with byte_index and frame_end on the footer. Each accepted item
// goes through the shared 13x13 multiplier and adder (MUL_A, MUL_B, ADD), a sign step,
// the 12-step restoring divide by the input span (bypassed on a zero span or a negative
// quotient), a pack step, one emit step per byte while the output slot is free and a
// closing step (flags and footer follow the last channel); the core then returns to idle.
// item_stall stays high until the item is done: for the last channel, until the footer
// is loaded into the output register; otherwise through the closing emit step after
// the last byte, which waits for a free output slot. Config writes are taken only when
// the core is idle and the output register is empty.
`default_nettype none
`include "sbus_frame_encoder_scaled_core_assert.svh"

module sbus_frame_encoder_scaled_core #(
  parameter int CHANNEL_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [11:0] channel_value,
  input  logic        signal_loss,
  input  logic        failsafe,
  output logic        byte_valid,
  input  logic        byte_stall,
  output logic [7:0]  frame_byte,
  output logic [4:0]  byte_index,
  output logic        frame_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int CH_W = $clog2(CHANNEL_COUNT);

  sbusfe_pkg::state_t state;

  logic [11:0] in_low;
  logic [11:0] in_high;
  logic [10:0] out_low;
  logic [10:0] out_high;

  logic [11:0] value;
  logic        loss;
  logic        fs;

  logic signed [sbusfe_pkg::NUM_W-1:0]   prod;
  logic signed [sbusfe_pkg::NUM_W-1:0]   acc;
  logic        [sbusfe_pkg::CODE_W-1:0]  code;

  logic [sbusfe_pkg::STORE_W-1:0] bit_store;
  logic [sbusfe_pkg::HELD_W-1:0]  bits_held;
  logic [sbusfe_pkg::IDX_W-1:0]   byte_count;
  logic [CH_W-1:0]                channel_count;
  logic                           hdr_pending;

  logic signed [12:0] span;
  logic signed [12:0] out_span;
  logic signed [12:0] v_off;
  logic signed [12:0] mul_a;
  logic signed [12:0] mul_b;
  logic signed [sbusfe_pkg::NUM_W-1:0] mul_p;

  logic [sbusfe_pkg::NUM_MAG_W-1:0] acc_abs;
  logic [sbusfe_pkg::DIV_W-1:0]     span_abs;
  logic                             quot_neg;
  logic                             div_start;
  logic                             div_done;
  logic [sbusfe_pkg::QUOT_W-1:0]    div_q;

  logic                           slot_free;
  logic                           last_ch;
  logic                           emit_load;
  logic [sbusfe_pkg::BYTE_W-1:0]  emit_byte;
  logic                           emit_end;

  assign item_stall = rst || (state != sbusfe_pkg::S_IDLE);
  assign cfg_ready  = !rst && (state == sbusfe_pkg::S_IDLE) && !byte_valid;
  assign slot_free  = !byte_valid || !byte_stall;
  assign last_ch    = (channel_count == CH_W'(CHANNEL_COUNT - 1));

  assign span     = $signed({1'b0, in_high}) - $signed({1'b0, in_low});
  assign out_span = $signed({2'b0, out_high}) - $signed({2'b0, out_low});
  assign v_off    = $signed({1'b0, value}) - $signed({1'b0, in_low});

  // shared multiplier: out_low*span, then offset*out_span
  assign mul_a = (state == sbusfe_pkg::S_MUL_A) ? $signed({2'b0, out_low}) : v_off;
  assign mul_b = (state == sbusfe_pkg::S_MUL_A) ? span : out_span;
  assign mul_p = mul_a * mul_b;

  assign acc_abs   = acc[sbusfe_pkg::NUM_W-1] ? sbusfe_pkg::NUM_MAG_W'(-acc)
                                              : sbusfe_pkg::NUM_MAG_W'(acc);
  assign span_abs  = span[12] ? sbusfe_pkg::DIV_W'(-span) : sbusfe_pkg::DIV_W'(span);
  assign quot_neg  = acc[sbusfe_pkg::NUM_W-1] ^ span[12];
  assign div_start = (state == sbusfe_pkg::S_SIGN) && (span != '0) && !quot_neg;

  sbusfe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_abs),
    .divisor  (span_abs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    emit_load = 1'b0;
    emit_byte = sbusfe_pkg::FRAME_HEADER;
    emit_end  = 1'b0;
    if (slot_free) begin
      if (state == sbusfe_pkg::S_EMIT) begin
        if (hdr_pending) begin
          emit_load = 1'b1;
        end else if (bits_held >= 5'(sbusfe_pkg::BYTE_W)) begin
          emit_load = 1'b1;
          emit_byte = bit_store[sbusfe_pkg::BYTE_W-1:0];
        end
      end else if (state == sbusfe_pkg::S_FLAG) begin
        emit_load = 1'b1;
        emit_byte = {4'b0, fs, loss, 2'b0};
      end else if (state == sbusfe_pkg::S_FOOT) begin
        emit_load = 1'b1;
        emit_byte = sbusfe_pkg::FRAME_FOOTER;
        emit_end  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sbusfe_pkg::S_IDLE;
      in_low        <= sbusfe_pkg::IN_LOW_RESET;
      in_high       <= sbusfe_pkg::IN_HIGH_RESET;
      out_low       <= sbusfe_pkg::OUT_LOW_RESET;
      out_high      <= sbusfe_pkg::OUT_HIGH_RESET;
      bit_store     <= '0;
      bits_held     <= '0;
      byte_count    <= '0;
      channel_count <= '0;
      hdr_pending   <= 1'b0;
      byte_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sbusfe_pkg::REG_IN_LOW:   in_low   <= cfg_data;
          sbusfe_pkg::REG_IN_HIGH:  in_high  <= cfg_data;
          sbusfe_pkg::REG_OUT_LOW:  out_low  <= cfg_data[10:0];
          sbusfe_pkg::REG_OUT_HIGH: out_high <= cfg_data[10:0];
        endcase
      end

      if (emit_load) begin
        byte_valid <= 1'b1;
        byte_count <= emit_end ? '0 : byte_count + 1'b1;
      end else if (!byte_stall) begin
        byte_valid <= 1'b0;
      end

      unique case (state)
        sbusfe_pkg::S_IDLE: begin
          if (item_valid) begin
            state <= sbusfe_pkg::S_MUL_A;
          end
        end
        sbusfe_pkg::S_MUL_A: state <= sbusfe_pkg::S_MUL_B;
        sbusfe_pkg::S_MUL_B: state <= sbusfe_pkg::S_ADD;
        sbusfe_pkg::S_ADD:   state <= sbusfe_pkg::S_SIGN;
        sbusfe_pkg::S_SIGN: begin
          state <= div_start ? sbusfe_pkg::S_DIV : sbusfe_pkg::S_PACK;
        end
        sbusfe_pkg::S_DIV: begin
          if (div_done) begin
            state <= sbusfe_pkg::S_PACK;
          end
        end
        sbusfe_pkg::S_PACK: begin
          hdr_pending <= (channel_count == '0);
          if (channel_count == '0) begin
            bit_store  <= sbusfe_pkg::STORE_W'(code);
            bits_held  <= sbusfe_pkg::HELD_W'(sbusfe_pkg::CODE_W);
            byte_count <= '0;
          end else begin
            bit_store <= bit_store | (sbusfe_pkg::STORE_W'(code) << bits_held);
            bits_held <= bits_held + sbusfe_pkg::HELD_W'(sbusfe_pkg::CODE_W);
          end
          state <= sbusfe_pkg::S_EMIT;
        end
        sbusfe_pkg::S_EMIT: begin
          if (slot_free) begin
            if (hdr_pending) begin
              hdr_pending <= 1'b0;
            end else if (bits_held >= 5'(sbusfe_pkg::BYTE_W)) begin
              bit_store <= bit_store >> sbusfe_pkg::BYTE_W;
              bits_held <= bits_held - 5'(sbusfe_pkg::BYTE_W);
            end else if (last_ch) begin
              state <= sbusfe_pkg::S_FLAG;
            end else begin
              channel_count <= channel_count + 1'b1;
              state         <= sbusfe_pkg::S_IDLE;
            end
          end
        end
        sbusfe_pkg::S_FLAG: begin
          if (slot_free) begin
            state <= sbusfe_pkg::S_FOOT;
          end
        end
        sbusfe_pkg::S_FOOT: begin
          if (slot_free) begin
            channel_count <= '0;
            bit_store     <= '0;
            bits_held     <= '0;
            state         <= sbusfe_pkg::S_IDLE;
          end
        end
        default: state <= sbusfe_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == sbusfe_pkg::S_IDLE && item_valid) begin
      value <= channel_value;
      loss  <= signal_loss;
      fs    <= failsafe;
    end

    if (state == sbusfe_pkg::S_MUL_A) begin
      prod <= mul_p;
    end else if (state == sbusfe_pkg::S_MUL_B) begin
      acc  <= prod;
      prod <= mul_p;
    end else if (state == sbusfe_pkg::S_ADD) begin
      acc <= acc + prod;
    end

    if (state == sbusfe_pkg::S_SIGN) begin
      if (span == '0) begin
        code <= out_low;
      end else if (quot_neg) begin
        code <= '0;
      end
    end else if (state == sbusfe_pkg::S_DIV && div_done) begin
      code <= div_q[sbusfe_pkg::QUOT_W-1] ? sbusfe_pkg::CODE_MAX
                                          : div_q[sbusfe_pkg::CODE_W-1:0];
    end

    if (emit_load) begin
      frame_byte <= emit_byte;
      byte_index <= byte_count;
      frame_end  <= emit_end;
    end
  end

  `SBUSFE_ASSERT_NOW(a_footer_index, byte_valid && frame_end,
    byte_index == sbusfe_pkg::FOOTER_INDEX, "footer byte not at frame position 24")
  `SBUSFE_ASSERT_NEXT(a_footer_wraps, emit_load && emit_end,
    channel_count == '0 && bits_held == '0 && byte_count == '0,
    "frame state not cleared with footer")
  `SBUSFE_ASSERT_NOW(a_idle_drained, state == sbusfe_pkg::S_IDLE,
    bits_held < 5'(sbusfe_pkg::BYTE_W), "whole byte left in bit store at idle")
  `SBUSFE_ASSERT_NEXT(a_item_starts, item_valid && !item_stall,
    state == sbusfe_pkg::S_MUL_A, "accepted item did not start the multiply")

endmodule

`default_nettype wire

@@ tb/sv/tb_sbus_frame_encoder_scaled_core.sv @@
module tb_sbus_frame_encoder_scaled_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CHANNELS = 16;
  localparam logic [7:0] FLAG_SIGNAL_LOSS = 8'h04;
  localparam logic [7:0] FLAG_FAILSAFE = 8'h08;

  typedef struct packed {
    logic [7:0] data;
    logic [4:0] pos;
    logic       last;
  } sbus_byte_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [11:0] channel_value;
  logic        signal_loss;
  logic        failsafe;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  frame_byte;
  logic [4:0]  byte_index;
  logic        frame_end;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;

  // scaling registers as the encoder should hold them
  logic [11:0] map_in_low = sbusfe_pkg::IN_LOW_RESET;
  logic [11:0] map_in_high = sbusfe_pkg::IN_HIGH_RESET;
  logic [10:0] map_out_low = sbusfe_pkg::OUT_LOW_RESET;
  logic [10:0] map_out_high = sbusfe_pkg::OUT_HIGH_RESET;

  // frame packing state
  logic [3:0]  chan_idx = '0;
  logic [17:0] bit_acc = '0;
  int          acc_bits = 0;
  logic [4:0]  byte_pos = '0;

  sbus_byte_t expected_bytes[$];
  int         err_count = 0;
  int         items_sent = 0;
  int         hold_cycles = 0;
  bit         src_gaps = 1'b1;
  bit         sink_gaps = 1'b1;

  sbus_frame_encoder_scaled_core #(.CHANNEL_COUNT(NUM_CHANNELS)) DUT (.*);

  always #4 clk = ~clk;

  function automatic logic [10:0] map_code(logic [11:0] value);
    longint span, num, quot;
    span = longint'(map_in_high) - longint'(map_in_low);
    if (span == 0) return map_out_low;
    num = longint'(map_out_low) * span
        + (longint'(value) - longint'(map_in_low))
        * (longint'(map_out_high) - longint'(map_out_low));
    quot = num / span;
    if (quot < 0) quot = 0;
    if (quot > longint'(sbusfe_pkg::CODE_MAX)) quot = longint'(sbusfe_pkg::CODE_MAX);
    return 11'(quot);
  endfunction

  function automatic void queue_byte(logic [7:0] data, logic last);
    expected_bytes.push_back('{data: data, pos: byte_pos, last: last});
    byte_pos++;
  endfunction

  function automatic void encode_channel(logic [11:0] value, logic loss, logic fs);
    logic [7:0] flags;
    if (chan_idx == 0) begin
      byte_pos = '0;
      bit_acc = '0;
      acc_bits = 0;
      queue_byte(sbusfe_pkg::FRAME_HEADER, 1'b0);
    end
    bit_acc = bit_acc | ({7'd0, map_code(value)} << acc_bits);
    acc_bits += sbusfe_pkg::CODE_W;
    while (acc_bits >= 8) begin
      queue_byte(bit_acc[7:0], 1'b0);
      bit_acc = bit_acc >> 8;
      acc_bits -= 8;
    end
    if (chan_idx == NUM_CHANNELS - 1) begin
      flags = 8'h00;
      if (loss) flags |= FLAG_SIGNAL_LOSS;
      if (fs) flags |= FLAG_FAILSAFE;
      queue_byte(flags, 1'b0);
      queue_byte(sbusfe_pkg::FRAME_FOOTER, 1'b1);
      chan_idx = '0;
      bit_acc = '0;
      acc_bits = 0;
      byte_pos = '0;
    end else begin
      chan_idx++;
    end
  endfunction

  task automatic send_channel(logic [11:0] value, logic loss, logic fs);
    int gap;
    gap = src_gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    channel_value <= value;
    signal_loss <= loss;
    failsafe <= fs;
    do @(posedge clk); while (item_stall);
    encode_channel(value, loss, fs);
    items_sent++;
  endtask

  task automatic wait_frame_idle();
    item_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sbusfe_pkg::REG_IN_LOW:   map_in_low = value;
      sbusfe_pkg::REG_IN_HIGH:  map_in_high = value;
      sbusfe_pkg::REG_OUT_LOW:  map_out_low = value[10:0];
      sbusfe_pkg::REG_OUT_HIGH: map_out_high = value[10:0];
    endcase
  endtask

  task automatic load_scaling(logic [11:0] in_lo, logic [11:0] in_hi,
                              logic [11:0] out_lo, logic [11:0] out_hi);
    wait_frame_idle();
    write_reg(sbusfe_pkg::REG_IN_LOW, in_lo);
    write_reg(sbusfe_pkg::REG_IN_HIGH, in_hi);
    write_reg(sbusfe_pkg::REG_OUT_LOW, out_lo);
    write_reg(sbusfe_pkg::REG_OUT_HIGH, out_hi);
    cfg_valid <= 1'b0;
  endtask

  // one frame, rescaled mid-frame: reset mapping, zero span, inverted span, saturation
  task automatic test_directed_frame();
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    send_channel(12'd0, 1'b1, 1'b1);
    send_channel(12'd4095, 1'b0, 1'b1);
    send_channel(12'd1000, 1'b1, 1'b0);
    send_channel(12'd2000, 1'b0, 1'b0);
    send_channel(12'd1500, 1'b0, 1'b0);
    send_channel(12'd1999, 1'b1, 1'b1);
    load_scaling(12'd3000, 12'd3000, 12'd1234, 12'd77);
    send_channel(12'd0, 1'b0, 1'b0);
    send_channel(12'd4095, 1'b1, 1'b0);
    send_channel(12'd3000, 1'b0, 1'b1);
    load_scaling(12'd4095, 12'd0, 12'h800, 12'hFFF);
    send_channel(12'd0, 1'b0, 1'b0);
    send_channel(12'd4095, 1'b0, 1'b0);
    send_channel(12'd2048, 1'b1, 1'b1);
    load_scaling(12'd2000, 12'd2001, 12'd0, 12'd2047);
    send_channel(12'd0, 1'b0, 1'b0);
    send_channel(12'd4095, 1'b0, 1'b0);
    send_channel(12'd2000, 1'b0, 1'b0);
    send_channel(12'd2001, 1'b1, 1'b1);
  endtask

  task automatic test_random_frames(int target);
    int burst, sel;
    logic [11:0] a, b, c, d, lo, hi, value;
    while (items_sent < target) begin
      sel = $urandom_range(0, 5);
      case (sel)
        0: begin a = sbusfe_pkg::IN_LOW_RESET; b = sbusfe_pkg::IN_HIGH_RESET;
                 c = 12'(sbusfe_pkg::OUT_LOW_RESET);
                 d = 12'(sbusfe_pkg::OUT_HIGH_RESET); end
        1: begin a = 12'd0; b = 12'd4095; c = 12'd0; d = 12'd2047; end
        2: begin a = 12'd4095; b = 12'd0; c = 12'd2047; d = 12'd0; end
        3: begin a = 12'($urandom); b = a; c = 12'($urandom); d = 12'($urandom); end
        4: begin a = 12'($urandom); b = 12'($urandom); c = 12'($urandom);
                 d = 12'($urandom); end
        default: begin
          a = 12'($urandom_range(0, 4095 - 64));
          b = a + 12'($urandom_range(1, 64));
          c = 12'($urandom_range(0, 1023));
          d = 12'($urandom_range(1024, 2047));
        end
      endcase
      load_scaling(a, b, c, d);
      sel = $urandom_range(0, 3);
      src_gaps = sel[0];
      sink_gaps = sel[1];
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      burst = $urandom_range(8, 40);
      repeat (burst) begin
        if ($urandom_range(0, 3) == 0) value = 12'($urandom);
        else value = 12'($urandom_range(lo, hi));
        send_channel(value, 1'($urandom), 1'($urandom));
      end
    end
  endtask

  // sink holds off for a long stretch while channels keep coming back to back
  task automatic test_output_backpressure();
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    hold_cycles = 300;
    repeat (24) send_channel(12'($urandom), 1'($urandom), 1'($urandom));
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  initial begin : byte_sink
    int pause_len;
    byte_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        byte_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        byte_stall <= 1'b0;
      end else if (sink_gaps && byte_valid && !byte_stall) begin
        pause_len = $urandom_range(0, 9);
        if (pause_len > 0) begin
          byte_stall <= 1'b1;
          repeat (pause_len) @(posedge clk);
          byte_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_bytes
    sbus_byte_t want;
    if (!rst && byte_valid && !byte_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte transaction: frame_byte %0h byte_index %0d",
               frame_byte, byte_index);
        err_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (frame_byte !== want.data) begin
          $error("frame_byte: expected %0h, got %0h", want.data, frame_byte);
          err_count++;
        end
        if (byte_index !== want.pos) begin
          $error("byte_index: expected %0d, got %0d", want.pos, byte_index);
          err_count++;
        end
        if (frame_end !== want.last) begin
          $error("frame_end: expected %0b, got %0b", want.last, frame_end);
          err_count++;
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    channel_value <= '0;
    signal_loss <= 1'b0;
    failsafe <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= sbusfe_pkg::REG_IN_LOW;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_frame();
    test_random_frames(220);
    test_output_backpressure();
    wait_frame_idle();
    repeat (30) @(posedge clk);
    if (err_count == 0 && expected_bytes.size() == 0) begin
      $display("sbus_frame_encoder_scaled_core test passed");
    end else begin
      $display("sbus_frame_encoder_scaled_core test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("sbus_frame_encoder_scaled_core test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sbusfe_pkg.sv
rtl/sbusfe_div.sv
rtl/sbus_frame_encoder_scaled_core.sv
tb/sv/tb_sbus_frame_encoder_scaled_core.sv
